### sv/mtk_pkg.sv
// Shared types, codes and the key character table for the multi-tap text entry core.
// No dependencies; every other file refers to this package by scoped names.
package mtk_pkg;

  localparam int unsigned MaxBuffer = 256;
  localparam int unsigned BufSizeW  = 9;
  localparam int unsigned TextPosW  = 9;
  localparam int unsigned CalcW     = 11;

  // Reset values of the configuration registers
  localparam logic [BufSizeW-1:0] BufSizeRst    = 9'd32;
  localparam logic [31:0]         TapTimeoutRst = 32'd240000000;

  localparam logic [BufSizeW-1:0] BufSizeMax = BufSizeW'(MaxBuffer);

  // Register indexes on the configuration port
  localparam logic RegBufferSize = 1'b0;
  localparam logic RegTapTimeout = 1'b1;

  // Request types
  localparam logic ReqKeyPress = 1'b0;
  localparam logic ReqTimeout  = 1'b1;

  // Special key codes
  localparam logic [3:0] KeyLastDigit = 4'd9;
  localparam logic [3:0] KeyClear     = 4'd10;
  localparam logic [3:0] KeyShift     = 4'd11;

  localparam logic [6:0] CaseOffset = 7'h20;
  localparam logic [6:0] CharLowA   = 7'h61;
  localparam logic [6:0] CharLowZ   = 7'h7a;

  typedef enum logic [1:0] {
    TMR_STOP    = 2'd0,
    TMR_RESTART = 2'd1,
    TMR_KEEP    = 2'd2
  } timer_cmd_e;

  typedef struct packed {
    logic [BufSizeW-1:0] buffer_size;
    logic [31:0]         tap_timeout;
  } cfg_t;

  typedef struct packed {
    logic [TextPosW-1:0] text_pos;     // signed, -1 means nothing committed
    logic [3:0]          active_key;
    logic                seq_open;
    logic [2:0]          tap_count;
    logic                capital;
    logic [31:0]         last_time;
  } state_t;

  typedef struct packed {
    logic       write_enable;
    logic [7:0] write_index;
    logic [6:0] write_char;
    logic       terminate_next;
    timer_cmd_e timer_command;
    logic       ui_event;
    logic       buffer_full;
    logic [7:0] committed_length;
    logic       pending_active;
  } result_t;

  // Number of characters a digit key cycles through
  function automatic logic [2:0] key_len(input logic [3:0] key);
    logic [2:0] len;
    unique case (key)
      4'd0:                   len = 3'd2;
      4'd1, 4'd7, 4'd9:       len = 3'd5;
      default:                len = 3'd4;
    endcase
    return len;
  endfunction

  // Character for a digit key at a given tap
  function automatic logic [6:0] key_char(input logic [3:0] key, input logic [2:0] tap);
    logic [6:0] ch;
    ch = 7'h00;
    unique case (key)
      4'd0: begin
        unique case (tap)
          3'd0:    ch = 7'h20;
          3'd1:    ch = 7'h30;
          default: ch = 7'h00;
        endcase
      end
      4'd1: begin
        unique case (tap)
          3'd0:    ch = 7'h31;
          3'd1:    ch = 7'h2e;
          3'd2:    ch = 7'h2c;
          3'd3:    ch = 7'h21;
          3'd4:    ch = 7'h3f;
          default: ch = 7'h00;
        endcase
      end
      4'd2: begin
        unique case (tap)
          3'd0:    ch = 7'h61;
          3'd1:    ch = 7'h62;
          3'd2:    ch = 7'h63;
          3'd3:    ch = 7'h32;
          default: ch = 7'h00;
        endcase
      end
      4'd3: begin
        unique case (tap)
          3'd0:    ch = 7'h64;
          3'd1:    ch = 7'h65;
          3'd2:    ch = 7'h66;
          3'd3:    ch = 7'h33;
          default: ch = 7'h00;
        endcase
      end
      4'd4: begin
        unique case (tap)
          3'd0:    ch = 7'h67;
          3'd1:    ch = 7'h68;
          3'd2:    ch = 7'h69;
          3'd3:    ch = 7'h34;
          default: ch = 7'h00;
        endcase
      end
      4'd5: begin
        unique case (tap)
          3'd0:    ch = 7'h6a;
          3'd1:    ch = 7'h6b;
          3'd2:    ch = 7'h6c;
          3'd3:    ch = 7'h35;
          default: ch = 7'h00;
        endcase
      end
      4'd6: begin
        unique case (tap)
          3'd0:    ch = 7'h6d;
          3'd1:    ch = 7'h6e;
          3'd2:    ch = 7'h6f;
          3'd3:    ch = 7'h36;
          default: ch = 7'h00;
        endcase
      end
      4'd7: begin
        unique case (tap)
          3'd0:    ch = 7'h70;
          3'd1:    ch = 7'h71;
          3'd2:    ch = 7'h72;
          3'd3:    ch = 7'h73;
          3'd4:    ch = 7'h37;
          default: ch = 7'h00;
        endcase
      end
      4'd8: begin
        unique case (tap)
          3'd0:    ch = 7'h74;
          3'd1:    ch = 7'h75;
          3'd2:    ch = 7'h76;
          3'd3:    ch = 7'h38;
          default: ch = 7'h00;
        endcase
      end
      4'd9: begin
        unique case (tap)
          3'd0:    ch = 7'h77;
          3'd1:    ch = 7'h78;
          3'd2:    ch = 7'h79;
          3'd3:    ch = 7'h7a;
          3'd4:    ch = 7'h39;
          default: ch = 7'h00;
        endcase
      end
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

endpackage

### sv/mtk_cfg_regs.sv
// Configuration registers of the multi-tap text entry core behind an APB-style port.
// Depends on mtk_pkg for the register indexes, reset values and cfg_t.
module mtk_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output mtk_pkg::cfg_t cfg_o
);

  logic [mtk_pkg::BufSizeW-1:0] buffer_size_q;
  logic [31:0]                  tap_timeout_q;
  logic                         reg_idx;
  logic                         wr_en;

  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_size_q <= mtk_pkg::BufSizeRst;
      tap_timeout_q <= mtk_pkg::TapTimeoutRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        mtk_pkg::RegBufferSize: buffer_size_q <= pwdata[mtk_pkg::BufSizeW-1:0];
        mtk_pkg::RegTapTimeout: tap_timeout_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mtk_pkg::RegBufferSize: prdata = {{(32-mtk_pkg::BufSizeW){1'b0}}, buffer_size_q};
      mtk_pkg::RegTapTimeout: prdata = tap_timeout_q;
      default:                prdata = 32'd0;
    endcase
  end

  assign cfg_o.buffer_size = buffer_size_q;
  assign cfg_o.tap_timeout = tap_timeout_q;

endmodule

### sv/mtk_step.sv
// Next-state and result logic for one key or timeout word of the text entry core.
// Depends on mtk_pkg for state_t, result_t, cfg_t and the key table.
module mtk_step (
  input  mtk_pkg::cfg_t    cfg_i,
  input  mtk_pkg::state_t  st_i,
  input  logic             req_type_i,
  input  logic [3:0]       key_code_i,
  input  logic [31:0]      timestamp_i,
  output mtk_pkg::state_t  st_o,
  output mtk_pkg::result_t res_o
);

  localparam int unsigned W = mtk_pkg::CalcW;

  logic [mtk_pkg::BufSizeW-1:0] cap;
  logic signed [W-1:0]          cap_s;
  logic signed [W-1:0]          tp_s;
  logic signed [W-1:0]          tp_w;
  logic signed [W-1:0]          tp_inc;
  logic signed [W-1:0]          widx;
  logic                         we;
  logic                         term;
  logic                         ui;
  logic                         full;
  logic [6:0]                   wch;
  logic [6:0]                   ch;
  logic [31:0]                  elapsed;
  logic [2:0]                   tap_inc;
  mtk_pkg::timer_cmd_e          timer;

  assign cap     = (cfg_i.buffer_size > mtk_pkg::BufSizeMax) ? mtk_pkg::BufSizeMax
                                                             : cfg_i.buffer_size;
  assign cap_s   = $signed({{(W-mtk_pkg::BufSizeW){1'b0}}, cap});
  assign tp_s    = $signed({{(W-mtk_pkg::TextPosW){st_i.text_pos[mtk_pkg::TextPosW-1]}},
                            st_i.text_pos});
  assign elapsed = timestamp_i - st_i.last_time;
  assign tap_inc = st_i.tap_count + 3'd1;

  always_comb begin
    st_o  = st_i;
    tp_w  = tp_s;
    we    = 1'b0;
    term  = 1'b0;
    ui    = 1'b0;
    full  = 1'b0;
    widx  = '0;
    wch   = 7'h00;
    ch    = 7'h00;
    timer = mtk_pkg::TMR_KEEP;

    if (cap != '0) begin
      if (req_type_i == mtk_pkg::ReqTimeout) begin
        if (st_i.seq_open) begin
          if (tp_s < cap_s - W'(2)) tp_w = tp_s + W'(1);
          else                      full = 1'b1;
          st_o.seq_open  = 1'b0;
          st_o.tap_count = 3'd0;
        end
      end else begin
        timer = mtk_pkg::TMR_STOP;
        if (key_code_i == mtk_pkg::KeyClear) begin
          if (st_i.seq_open) begin
            // drop the pending character
            st_o.seq_open  = 1'b0;
            st_o.tap_count = 3'd0;
            we   = 1'b1;
            widx = tp_s + W'(1);
          end else if (tp_s >= 0) begin
            // backspace one committed character
            we   = 1'b1;
            widx = tp_s;
            tp_w = tp_s - W'(1);
          end
        end else if (key_code_i == mtk_pkg::KeyShift) begin
          st_o.capital = !st_i.capital;
        end else begin
          if (key_code_i <= mtk_pkg::KeyLastDigit) begin
            if (st_i.seq_open && (st_i.active_key == key_code_i)
                && (elapsed < cfg_i.tap_timeout)) begin
              st_o.tap_count = (tap_inc >= mtk_pkg::key_len(key_code_i)) ? 3'd0 : tap_inc;
            end else begin
              // commit whatever is pending, then open a new sequence
              if (st_i.seq_open) begin
                if (tp_s < cap_s - W'(2)) tp_w = tp_s + W'(1);
                else                      full = 1'b1;
              end
              st_o.capital    = 1'b0;
              st_o.active_key = key_code_i;
              st_o.seq_open   = 1'b1;
              st_o.tap_count  = 3'd0;
            end
            if (tp_w + W'(1) < cap_s - W'(1)) begin
              ch = mtk_pkg::key_char(key_code_i, st_o.tap_count);
              if (ch >= mtk_pkg::CharLowA && ch <= mtk_pkg::CharLowZ && st_o.capital) begin
                ch = ch - mtk_pkg::CaseOffset;
              end
              we   = 1'b1;
              widx = tp_w + W'(1);
              wch  = ch;
              term = 1'b1;
            end else begin
              full = 1'b1;
            end
            timer = mtk_pkg::TMR_RESTART;
          end
          st_o.last_time = timestamp_i;
          ui = 1'b1;
        end
      end
    end

    // suppress writes past a capacity that was lowered
    if (we && ((widx < 0) || (widx >= cap_s))) we = 1'b0;
    if (!we) begin
      widx = '0;
      wch  = 7'h00;
      term = 1'b0;
    end

    st_o.text_pos = tp_w[mtk_pkg::TextPosW-1:0];
  end

  assign tp_inc = tp_w + W'(1);

  assign res_o.write_enable     = we;
  assign res_o.write_index      = widx[7:0];
  assign res_o.write_char       = wch;
  assign res_o.terminate_next   = term;
  assign res_o.timer_command    = timer;
  assign res_o.ui_event         = ui;
  assign res_o.buffer_full      = full;
  assign res_o.committed_length = tp_inc[7:0];
  assign res_o.pending_active   = st_o.seq_open;

endmodule

### sv/multitap_keypad_text_entry_core.sv
// Top level of the multi-tap keypad text entry core: input register, state, result register.
// Depends on mtk_pkg, mtk_cfg_regs and mtk_step.
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_ready_o   req_type_i, key_code_i, timestamp_i
//   out       output     out_valid_o / out_ready_i write_enable_o .. pending_active_o
//   cfg       input      APB psel/penable/pready   paddr, pwdata, prdata
//
// One word per cycle sustained while the result side takes every word; an accepted word passes
// from the input register into the result register, where its result can be taken.
// The path is input register -> table lookup and compares -> result register + state.
// The input register accepts while the result register waits; the input stalls only when
// both registers hold a word and the result is not taken.
// Reset clears the position to nothing committed, closes the sequence and restores
// buffer_size 32 and tap_timeout 240000000.
module multitap_keypad_text_entry_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [3:0]  key_code_i,
  input  logic [31:0] timestamp_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        write_enable_o,
  output logic [7:0]  write_index_o,
  output logic [6:0]  write_char_o,
  output logic        terminate_next_o,
  output logic [1:0]  timer_command_o,
  output logic        ui_event_o,
  output logic        buffer_full_o,
  output logic [7:0]  committed_length_o,
  output logic        pending_active_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  mtk_pkg::cfg_t    cfg;
  mtk_pkg::state_t  st_q, st_d;
  mtk_pkg::result_t res_d, res_q;

  logic        in_valid_q;
  logic        req_q;
  logic [3:0]  key_q;
  logic [31:0] ts_q;
  logic        out_valid_q;
  logic        advance;

  mtk_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mtk_step u_step (
    .cfg_i       (cfg),
    .st_i        (st_q),
    .req_type_i  (req_q),
    .key_code_i  (key_q),
    .timestamp_i (ts_q),
    .st_o        (st_d),
    .res_o       (res_d)
  );

  // move a word into the result register when it is empty or being drained
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q.text_pos   <= '1;
      st_q.active_key <= 4'd0;
      st_q.seq_open   <= 1'b0;
      st_q.tap_count  <= 3'd0;
      st_q.capital    <= 1'b0;
      st_q.last_time  <= 32'd0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (advance) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= req_type_i;
      key_q <= key_code_i;
      ts_q  <= timestamp_i;
    end
    if (advance) res_q <= res_d;
  end

  assign out_valid_o        = out_valid_q;
  assign write_enable_o     = res_q.write_enable;
  assign write_index_o      = res_q.write_index;
  assign write_char_o       = res_q.write_char;
  assign terminate_next_o   = res_q.terminate_next;
  assign timer_command_o    = res_q.timer_command;
  assign ui_event_o         = res_q.ui_event;
  assign buffer_full_o      = res_q.buffer_full;
  assign committed_length_o = res_q.committed_length;
  assign pending_active_o   = res_q.pending_active;

endmodule

### test/multitap_keypad_text_entry_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the multi-tap keypad text entry core: directed key strokes,
// randomized stroke sequences over several buffer and timeout settings, and a stroke predictor.
// Depends on mtk_pkg and multitap_keypad_text_entry_core.
module multitap_keypad_text_entry_core_tb;

  localparam int unsigned StallLimit = 5000;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic        in_ready_o;
  logic        req_type_i       = mtk_pkg::ReqKeyPress;
  logic [3:0]  key_code_i       = 4'd0;
  logic [31:0] timestamp_i      = 32'd0;
  logic        out_valid_o;
  logic        out_ready_i      = 1'b0;
  logic        write_enable_o;
  logic [7:0]  write_index_o;
  logic [6:0]  write_char_o;
  logic        terminate_next_o;
  logic [1:0]  timer_command_o;
  logic        ui_event_o;
  logic        buffer_full_o;
  logic [7:0]  committed_length_o;
  logic        pending_active_o;
  logic        psel             = 1'b0;
  logic        penable          = 1'b0;
  logic        pwrite           = 1'b0;
  logic [2:0]  paddr            = 3'd0;
  logic [31:0] pwdata           = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  multitap_keypad_text_entry_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .req_type_i         (req_type_i),
    .key_code_i         (key_code_i),
    .timestamp_i        (timestamp_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .write_enable_o     (write_enable_o),
    .write_index_o      (write_index_o),
    .write_char_o       (write_char_o),
    .terminate_next_o   (terminate_next_o),
    .timer_command_o    (timer_command_o),
    .ui_event_o         (ui_event_o),
    .buffer_full_o      (buffer_full_o),
    .committed_length_o (committed_length_o),
    .pending_active_o   (pending_active_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Characters each digit key steps through, in tap order
  string key_map [10] = '{" 0", "1.,!?", "abc2", "def3", "ghi4", "jkl5", "mno6", "pqrs7",
                          "tuv8", "wxyz9"};

  // Predicted register and entry state
  logic [8:0]  buf_size  = mtk_pkg::BufSizeRst;
  logic [31:0] tap_limit = mtk_pkg::TapTimeoutRst;
  int          text_pos  = -1;
  logic [3:0]  cur_key   = 4'd0;
  bit          seq_open  = 1'b0;
  int          tap_idx   = 0;
  bit          caps_on   = 1'b0;
  logic [31:0] last_ts   = 32'd0;

  mtk_pkg::result_t step_results_due [$];
  int               mismatch_count = 0;
  int unsigned      quiet_cycles   = 0;

  int          send_idle_pct   = 0;
  int          ready_stall_pct = 0;
  int          hold_len        = 0;
  int          hold_seq        = 0;
  logic [31:0] key_clock       = 32'd0;

  function automatic bit commit_refused(input int cap);
    if (text_pos < cap - 2) begin
      text_pos++;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic mtk_pkg::result_t predict_keystroke(input logic req,
                                                         input logic [3:0] key,
                                                         input logic [31:0] ts);
    mtk_pkg::result_t    res;
    int                  cap;
    int                  widx;
    bit                  we;
    bit                  term;
    bit                  ui;
    bit                  full;
    logic [6:0]          ch;
    logic [31:0]         elapsed;
    mtk_pkg::timer_cmd_e tmr;
    cap = (int'(buf_size) > int'(mtk_pkg::MaxBuffer)) ? int'(mtk_pkg::MaxBuffer)
                                                      : int'(buf_size);
    we = 1'b0; term = 1'b0; ui = 1'b0; full = 1'b0;
    widx = 0; ch = 7'd0; tmr = mtk_pkg::TMR_KEEP;
    if (cap >= 1) begin
      if (req == mtk_pkg::ReqTimeout) begin
        if (seq_open) begin
          full = commit_refused(cap);
          seq_open = 1'b0;
          tap_idx = 0;
        end
      end else begin
        tmr = mtk_pkg::TMR_STOP;
        if (key == mtk_pkg::KeyClear) begin
          if (seq_open) begin
            seq_open = 1'b0;
            tap_idx = 0;
            we = 1'b1;
            widx = text_pos + 1;
          end else if (text_pos >= 0) begin
            we = 1'b1;
            widx = text_pos;
            text_pos--;
          end
        end else if (key == mtk_pkg::KeyShift) begin
          caps_on = !caps_on;
        end else begin
          if (key <= mtk_pkg::KeyLastDigit) begin
            elapsed = ts - last_ts;
            if (seq_open && cur_key == key && elapsed < tap_limit) begin
              tap_idx = (tap_idx + 1) % key_map[key].len();
            end else begin
              // a different key or a late tap commits what is pending
              if (seq_open && commit_refused(cap)) full = 1'b1;
              caps_on = 1'b0;
              cur_key = key;
              seq_open = 1'b1;
              tap_idx = 0;
            end
            if (text_pos + 1 < cap - 1) begin
              ch = 7'(key_map[key][tap_idx]);
              if (caps_on && ch >= mtk_pkg::CharLowA && ch <= mtk_pkg::CharLowZ) begin
                ch -= mtk_pkg::CaseOffset;
              end
              we = 1'b1;
              widx = text_pos + 1;
              term = 1'b1;
            end else begin
              full = 1'b1;
            end
            tmr = mtk_pkg::TMR_RESTART;
          end
          last_ts = ts;
          ui = 1'b1;
        end
      end
    end
    // drop writes that land outside a shrunken buffer
    if (we && (widx < 0 || widx >= cap)) we = 1'b0;
    res = '0;
    if (we) begin
      res.write_enable   = 1'b1;
      res.write_index    = 8'(widx);
      res.write_char     = ch;
      res.terminate_next = term;
    end
    res.timer_command    = tmr;
    res.ui_event         = ui;
    res.buffer_full      = full;
    res.committed_length = 8'(text_pos + 1);
    res.pending_active   = seq_open;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Predict on accepted input words, check accepted result words, guard against hangs
  always @(posedge clk_i) begin
    mtk_pkg::result_t want;
    if (rst_ni) begin
      quiet_cycles++;
      if (in_valid_i && in_ready_o) begin
        step_results_due.push_back(predict_keystroke(req_type_i, key_code_i, timestamp_i));
        quiet_cycles = 0;
      end
      if (out_valid_o && out_ready_i) begin
        quiet_cycles = 0;
        if (step_results_due.size() == 0) begin
          $error("result word with no expectation pending");
          mismatch_count++;
        end else begin
          want = step_results_due.pop_front();
          check_field("write_enable", want.write_enable, write_enable_o);
          check_field("write_index", want.write_index, write_index_o);
          check_field("write_char", want.write_char, write_char_o);
          check_field("terminate_next", want.terminate_next, terminate_next_o);
          check_field("timer_command", want.timer_command, timer_command_o);
          check_field("ui_event", want.ui_event, ui_event_o);
          check_field("buffer_full", want.buffer_full, buffer_full_o);
          check_field("committed_length", want.committed_length, committed_length_o);
          check_field("pending_active", want.pending_active, pending_active_o);
        end
      end
      if (quiet_cycles >= StallLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Result side: random stalls plus an occasional long hold
  always @(negedge clk_i) begin
    int hold_left;
    int hold_seen;
    if (hold_seq != hold_seen) begin
      hold_left = hold_len;
      hold_seen = hold_seq;
    end
    if (hold_left > 0) begin
      out_ready_i = 1'b0;
      hold_left--;
    end else begin
      out_ready_i = ($urandom_range(99) >= ready_stall_pct);
    end
  end

  task automatic send_word(input logic req, input logic [3:0] key, input logic [31:0] ts);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    req_type_i  = req;
    key_code_i  = key;
    timestamp_i = ts;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (step_results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_register(input logic idx, input logic [31:0] value);
    logic [31:0] readback;
    @(negedge clk_i);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {idx, 2'b00}; pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == mtk_pkg::RegBufferSize) buf_size = value[8:0];
    else tap_limit = value;
    @(negedge clk_i);
    penable = 1'b0; pwrite = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = (idx == mtk_pkg::RegBufferSize) ? {23'd0, buf_size} : tap_limit;
    if (prdata !== readback) begin
      $error("prdata: expected %0d, got %0d", readback, prdata);
      mismatch_count++;
    end
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0;
  endtask

  // Mostly well-formed tap sequences, with timeouts, edits and noise mixed in
  task automatic send_random_stroke();
    logic        req;
    logic [3:0]  key;
    logic [31:0] delta;
    int          pick;
    req = mtk_pkg::ReqKeyPress;
    key = 4'($urandom_range(15));
    pick = $urandom_range(99);
    if (pick < 50) key = (seq_open && $urandom_range(99) < 60) ? cur_key : 4'($urandom_range(9));
    else if (pick < 62) req = mtk_pkg::ReqTimeout;
    else if (pick < 72) key = mtk_pkg::KeyClear;
    else if (pick < 78) key = mtk_pkg::KeyShift;
    else if (pick < 84) key = 4'($urandom_range(15, 12));
    else req = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 70) delta = 32'($urandom_range(64));
    else if (pick < 85) delta = tap_limit + 32'($urandom_range(2)) - 32'd1;
    else delta = $urandom;
    key_clock += delta;
    send_word(req, key, key_clock);
  endtask

  task automatic run_random_phase(input int count, input logic [31:0] size,
                                  input logic [31:0] timeout, input int idle_pct,
                                  input int stall_pct);
    wait_drained();
    set_register(mtk_pkg::RegBufferSize, size);
    set_register(mtk_pkg::RegTapTimeout, timeout);
    send_idle_pct   = idle_pct;
    ready_stall_pct = stall_pct;
    repeat (count) send_random_stroke();
  endtask

  task automatic test_directed_strokes();
    send_idle_pct   = 0;
    ready_stall_pct = 0;
    send_word(mtk_pkg::ReqTimeout, 4'd15, 32'd0);                  // nothing pending
    send_word(mtk_pkg::ReqKeyPress, mtk_pkg::KeyClear, 32'd0);     // nothing to remove
    send_word(mtk_pkg::ReqKeyPress, mtk_pkg::KeyShift, 32'd50);
    send_word(mtk_pkg::ReqKeyPress, 4'd2, 32'd100);        // new sequence drops capitals
    send_word(mtk_pkg::ReqKeyPress, 4'd2, 32'd200);
    send_word(mtk_pkg::ReqKeyPress, mtk_pkg::KeyShift, 32'd250);
    send_word(mtk_pkg::ReqKeyPress, 4'd2, 32'd300);
    send_word(mtk_pkg::ReqKeyPress, 4'd2, 32'd400);
    send_word(mtk_pkg::ReqKeyPress, 4'd2, 32'd500);        // wrap back to the first letter
    send_word(mtk_pkg::ReqKeyPress, 4'd8, 32'd600);
    send_word(mtk_pkg::ReqKeyPress, 4'd8, 32'd700);
    send_word(mtk_pkg::ReqKeyPress, 4'd8, 32'd800);
    send_word(mtk_pkg::ReqKeyPress, 4'd8, 32'd900);
    send_word(mtk_pkg::ReqKeyPress, 4'd8, 32'd1000);
    send_word(mtk_pkg::ReqKeyPress, 4'd12, 32'd1100);      // other key keeps the sequence
    send_word(mtk_pkg::ReqKeyPress, 4'd8, 32'd1200);
    send_word(mtk_pkg::ReqKeyPress, 4'd9, 32'hFFFF_FFF0);
    send_word(mtk_pkg::ReqKeyPress, 4'd9, 32'h0000_000F);  // elapsed time wraps
    send_word(mtk_pkg::ReqTimeout, 4'd0, 32'd20);
    send_word(mtk_pkg::ReqKeyPress, mtk_pkg::KeyClear, 32'd30);    // backspace
    send_word(mtk_pkg::ReqKeyPress, 4'd0, 32'hFFFF_FFFF);
    send_word(mtk_pkg::ReqKeyPress, mtk_pkg::KeyClear, 32'd40);    // drop the pending character
    send_word(mtk_pkg::ReqKeyPress, 4'd1, 32'd0);
    send_word(mtk_pkg::ReqKeyPress, 4'd15, 32'hFFFF_FFFF);
    send_word(mtk_pkg::ReqKeyPress, 4'd1, 32'd5);
  endtask

  task automatic test_random_traffic();
    run_random_phase(200, 32'd32, 32'd240000000, 0, 0);
    run_random_phase(200, 32'd8, 32'd100, 87, 0);
    run_random_phase(200, 32'd256, 32'd50, 0, 87);
    run_random_phase(150, 32'd3, 32'd0, 13, 13);
    run_random_phase(150, 32'd511, 32'hFFFF_FFFF, 0, 0);
  endtask

  // Commit until the largest buffer is full, then shrink it under the text
  task automatic test_fill_and_shrink();
    wait_drained();
    set_register(mtk_pkg::RegBufferSize, 32'd256);
    set_register(mtk_pkg::RegTapTimeout, 32'd0);
    send_idle_pct   = 0;
    ready_stall_pct = 0;
    repeat (310) begin
      key_clock += 32'($urandom_range(3));
      if ($urandom_range(9) == 0) begin
        send_word(mtk_pkg::ReqTimeout, 4'($urandom_range(15)), key_clock);
      end else begin
        send_word(mtk_pkg::ReqKeyPress, 4'($urandom_range(9)), key_clock);
      end
    end
    run_random_phase(60, 32'd16, 32'd40, 13, 13);
  endtask

  task automatic test_tiny_buffers();
    run_random_phase(40, 32'd1, 32'd1, 0, 0);
    run_random_phase(40, 32'd2, 32'd7, 87, 0);
    run_random_phase(40, 32'd0, 32'd100, 0, 87);
  endtask

  // Hold the result side while words keep coming, so the input stalls
  task automatic test_input_backpressure();
    wait_drained();
    set_register(mtk_pkg::RegBufferSize, 32'd300);
    set_register(mtk_pkg::RegTapTimeout, 32'd1000);
    send_idle_pct   = 0;
    ready_stall_pct = 0;
    hold_len = 80;
    hold_seq++;
    repeat (40) send_random_stroke();
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_strokes();
    test_random_traffic();
    test_fill_and_shrink();
    test_tiny_buffers();
    test_input_backpressure();
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
sv/mtk_pkg.sv
sv/mtk_cfg_regs.sv
sv/mtk_step.sv
sv/multitap_keypad_text_entry_core.sv
test/multitap_keypad_text_entry_core_tb.sv
